// ===== design/nlpd_pkg.sv =====
package nlpd_pkg;

	localparam int SlotCount = 4;
	localparam int IdCount   = 4;
	localparam int WordW     = 32;
	localparam int SlotW     = 2;
	localparam int RegIdxW   = 3;

	localparam logic [WordW-1:0] EndTypeReset     = 32'h1000_0000;
	localparam logic [WordW-1:0] IgnoredMaskReset = 32'd22;

	typedef enum logic [RegIdxW-1:0] {
		REG_SUB_ID_0,
		REG_SUB_ID_1,
		REG_SUB_ID_2,
		REG_SUB_ID_3,
		REG_SLOT_ENABLE,
		REG_EVENTS_TYPE,
		REG_END_TYPE,
		REG_IGNORED_MASK
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ENDIAN,
		PH_TYPE,
		PH_SKIP,
		PH_OPTSIZE,
		PH_OPTIONS,
		PH_HEADER,
		PH_NEVENTS,
		PH_EVSIZE,
		PH_EVHEAD,
		PH_SEVID,
		PH_SEVSIZE,
		PH_PAYLOAD,
		PH_TRAILING,
		PH_DISCARD
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_EVENTS,
		KIND_SKIP_MORE,
		KIND_SKIP_END
	} kind_t;

	typedef enum logic [1:0] {
		ST_RUNNING,
		ST_MORE,
		ST_NO_MORE,
		ST_ERROR
	} status_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_TRUNCATED,
		ERR_UNKNOWN_TYPE,
		ERR_EXTRA_WORDS,
		ERR_EVENT_MISMATCH,
		ERR_UNKNOWN_ID
	} err_t;

	typedef struct packed {
		logic [IdCount-1:0][WordW-1:0] sub_id;
		logic [IdCount-1:0]            slot_enable;
		logic [WordW-1:0]              events_type;
		logic [WordW-1:0]              end_type;
		logic [WordW-1:0]              ignored_mask;
	} cfg_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             first_word;
		logic             last_word;
	} in_t;

	typedef struct packed {
		logic             payload_valid;
		logic [WordW-1:0] payload;
		logic             empty_subevent;
		logic             end_of_subevent;
		logic [WordW-1:0] ev_num;
		logic [WordW-1:0] subevent_tag;
		logic [SlotW-1:0] unpacker_slot;
		logic [1:0]       cluster_status;
		logic [2:0]       error_code;
		logic [WordW-1:0] event_cluster_total;
		logic [WordW-1:0] event_total;
		logic [WordW-1:0] subevent_total;
	} out_t;

endpackage

// ===== design/nlpd_in_if.sv =====
interface nlpd_in_if;
	logic         valid;
	logic         ready;
	nlpd_pkg::in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/nlpd_out_if.sv =====
interface nlpd_out_if;
	logic          valid;
	logic          ready;
	nlpd_pkg::out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/nlpd_cfg_regs.sv =====
module nlpd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [nlpd_pkg::RegIdxW-1:0]   cfg_index,
	input  logic [nlpd_pkg::WordW-1:0]     cfg_data,
	output nlpd_pkg::cfg_t                 cfg
);

	nlpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sub_id       <= '0;
			cfg_q.slot_enable  <= '0;
			cfg_q.events_type  <= '0;
			cfg_q.end_type     <= nlpd_pkg::EndTypeReset;
			cfg_q.ignored_mask <= nlpd_pkg::IgnoredMaskReset;
		end else if (cfg_write) begin
			case (cfg_index)
				nlpd_pkg::REG_SUB_ID_0:     cfg_q.sub_id[0] <= cfg_data;
				nlpd_pkg::REG_SUB_ID_1:     cfg_q.sub_id[1] <= cfg_data;
				nlpd_pkg::REG_SUB_ID_2:     cfg_q.sub_id[2] <= cfg_data;
				nlpd_pkg::REG_SUB_ID_3:     cfg_q.sub_id[3] <= cfg_data;
				nlpd_pkg::REG_SLOT_ENABLE:  cfg_q.slot_enable <= cfg_data[nlpd_pkg::IdCount-1:0];
				nlpd_pkg::REG_EVENTS_TYPE:  cfg_q.events_type <= cfg_data;
				nlpd_pkg::REG_END_TYPE:     cfg_q.end_type <= cfg_data;
				nlpd_pkg::REG_IGNORED_MASK: cfg_q.ignored_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/nlpd_parser.sv =====
module nlpd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  nlpd_pkg::in_t  item,
	input  nlpd_pkg::cfg_t cfg,
	output nlpd_pkg::out_t res
);

	nlpd_pkg::phase_t ph_q, ph_d;
	nlpd_pkg::kind_t  kind_q, kind_d;
	logic [1:0]                    hp_q, hp_d;
	logic [nlpd_pkg::WordW-1:0]    opt_q, opt_d;
	logic [nlpd_pkg::WordW-1:0]    evl_q, evl_d;
	logic [nlpd_pkg::WordW-1:0]    ewl_q, ewl_d;
	logic [nlpd_pkg::WordW-1:0]    sel_q, sel_d;
	logic [nlpd_pkg::WordW-1:0]    scte_q, scte_d;
	logic [nlpd_pkg::WordW-1:0]    swl_q, swl_d;
	logic [nlpd_pkg::WordW-1:0]    eic_q, eic_d;
	logic [nlpd_pkg::WordW-1:0]    cev_q, cev_d;
	logic [nlpd_pkg::WordW-1:0]    csub_q, csub_d;
	logic [nlpd_pkg::SlotW-1:0]    cslot_q, cslot_d;
	logic [nlpd_pkg::WordW-1:0]    ecc_q, ecc_d;
	logic [nlpd_pkg::WordW-1:0]    evc_q, evc_d;
	logic [nlpd_pkg::WordW-1:0]    sbc_q, sbc_d;

	logic                          hit;
	logic [nlpd_pkg::SlotW-1:0]    hit_slot;
	nlpd_pkg::err_t                err, err_f;
	nlpd_pkg::status_t             status;
	logic                          done, pv, empty, eos;
	logic                          fin_sub, fin_ev, begin_sub;

	// lowest enabled slot wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int s = nlpd_pkg::SlotCount - 1; s >= 0; s--) begin
			if (cfg.slot_enable[s] && cfg.sub_id[s] == csub_q) begin
				hit      = 1'b1;
				hit_slot = nlpd_pkg::SlotW'(s);
			end
		end
	end

	always_comb begin : next_state
		ph_d      = ph_q;
		kind_d    = kind_q;
		hp_d      = hp_q;
		opt_d     = opt_q;
		evl_d     = evl_q;
		ewl_d     = ewl_q;
		sel_d     = sel_q;
		scte_d    = scte_q;
		swl_d     = swl_q;
		eic_d     = eic_q;
		cev_d     = cev_q;
		csub_d    = csub_q;
		cslot_d   = cslot_q;
		ecc_d     = ecc_q;
		evc_d     = evc_q;
		sbc_d     = sbc_q;
		err       = nlpd_pkg::ERR_NONE;
		done      = 1'b0;
		pv        = 1'b0;
		empty     = 1'b0;
		eos       = 1'b0;
		fin_sub   = 1'b0;
		fin_ev    = 1'b0;
		begin_sub = 1'b0;

		if (item.first_word) begin
			hp_d   = '0;
			kind_d = nlpd_pkg::KIND_NONE;
			opt_d  = '0;
			evl_d  = '0;
			ewl_d  = '0;
			sel_d  = '0;
			scte_d = '0;
			swl_d  = '0;
			eic_d  = '0;
			ph_d   = nlpd_pkg::PH_ENDIAN;
		end else begin
			case (ph_q)
				nlpd_pkg::PH_ENDIAN: ph_d = nlpd_pkg::PH_TYPE;
				nlpd_pkg::PH_TYPE: begin
					if (item.word == cfg.events_type) begin
						kind_d = nlpd_pkg::KIND_EVENTS;
						ecc_d  = ecc_q + 1'b1;
						ph_d   = nlpd_pkg::PH_OPTSIZE;
					end else if (item.word == cfg.end_type) begin
						kind_d = nlpd_pkg::KIND_SKIP_END;
						ph_d   = nlpd_pkg::PH_SKIP;
					end else if (item.word[31:5] == '0 && cfg.ignored_mask[item.word[4:0]]) begin
						kind_d = nlpd_pkg::KIND_SKIP_MORE;
						ph_d   = nlpd_pkg::PH_SKIP;
					end else begin
						err = nlpd_pkg::ERR_UNKNOWN_TYPE;
					end
				end
				nlpd_pkg::PH_OPTSIZE: begin
					opt_d = item.word;
					hp_d  = '0;
					ph_d  = (item.word != '0) ? nlpd_pkg::PH_OPTIONS : nlpd_pkg::PH_HEADER;
				end
				nlpd_pkg::PH_OPTIONS: begin
					opt_d = opt_q - 1'b1;
					if (opt_q == 32'd1)
						ph_d = nlpd_pkg::PH_HEADER;
				end
				nlpd_pkg::PH_HEADER: begin
					if (hp_q >= 2'd2)
						ph_d = nlpd_pkg::PH_NEVENTS;
					else
						hp_d = hp_q + 1'b1;
				end
				nlpd_pkg::PH_NEVENTS: begin
					evl_d = item.word;
					eic_d = item.word;
					if (item.word == '0)
						done = 1'b1;
					else
						ph_d = nlpd_pkg::PH_EVSIZE;
				end
				nlpd_pkg::PH_EVSIZE: begin
					if (item.word < 32'd3) begin
						err = nlpd_pkg::ERR_TRUNCATED;
					end else begin
						ewl_d = item.word;
						hp_d  = '0;
						ph_d  = nlpd_pkg::PH_EVHEAD;
					end
				end
				nlpd_pkg::PH_EVHEAD: begin
					ewl_d = ewl_q - 1'b1;
					if (hp_q == 2'd0) begin
						cev_d = item.word;
						hp_d  = 2'd1;
					end else if (hp_q == 2'd1) begin
						hp_d = 2'd2;
					end else begin
						sel_d  = item.word;
						scte_d = item.word;
						if (item.word == '0)
							fin_ev = 1'b1;
						else
							begin_sub = 1'b1;
					end
				end
				nlpd_pkg::PH_SEVID: begin
					csub_d = item.word;
					ewl_d  = ewl_q - 1'b1;
					ph_d   = nlpd_pkg::PH_SEVSIZE;
				end
				nlpd_pkg::PH_SEVSIZE: begin
					ewl_d = ewl_q - 1'b1;
					if (item.word > ewl_d) begin
						err = nlpd_pkg::ERR_TRUNCATED;
					end else if (!hit) begin
						err = nlpd_pkg::ERR_UNKNOWN_ID;
					end else begin
						cslot_d = hit_slot;
						swl_d   = item.word;
						if (item.word == '0) begin
							empty   = 1'b1;
							eos     = 1'b1;
							fin_sub = 1'b1;
						end else begin
							ph_d = nlpd_pkg::PH_PAYLOAD;
						end
					end
				end
				nlpd_pkg::PH_PAYLOAD: begin
					pv    = 1'b1;
					ewl_d = ewl_q - 1'b1;
					swl_d = swl_q - 1'b1;
					if (swl_q == 32'd1) begin
						eos     = 1'b1;
						fin_sub = 1'b1;
					end
				end
				nlpd_pkg::PH_TRAILING: err = nlpd_pkg::ERR_EXTRA_WORDS;
				default: ;
			endcase
		end

		if (fin_sub) begin
			sel_d = sel_q - 1'b1;
			if (sel_q == 32'd1)
				fin_ev = 1'b1;
			else
				begin_sub = 1'b1;
		end
		if (begin_sub) begin
			if (ewl_d < 32'd2)
				err = nlpd_pkg::ERR_TRUNCATED;
			else
				ph_d = nlpd_pkg::PH_SEVID;
		end
		if (fin_ev) begin
			if (ewl_d != '0) begin
				err = nlpd_pkg::ERR_EVENT_MISMATCH;
			end else begin
				sbc_d = sbc_q + scte_d;
				evl_d = evl_q - 1'b1;
				if (evl_q == 32'd1)
					done = 1'b1;
				else
					ph_d = nlpd_pkg::PH_EVSIZE;
			end
		end

		// end-of-cluster resolution
		err_f  = err;
		status = nlpd_pkg::ST_RUNNING;
		if (item.last_word && (err == nlpd_pkg::ERR_EVENT_MISMATCH ||
				err == nlpd_pkg::ERR_UNKNOWN_ID))
			err_f = nlpd_pkg::ERR_TRUNCATED;
		if (err_f != nlpd_pkg::ERR_NONE) begin
			status = nlpd_pkg::ST_ERROR;
			ph_d   = item.last_word ? nlpd_pkg::PH_IDLE : nlpd_pkg::PH_DISCARD;
		end else if (done) begin
			if (item.last_word) begin
				status = nlpd_pkg::ST_MORE;
				evc_d  = evc_q + eic_d;
				ph_d   = nlpd_pkg::PH_IDLE;
			end else begin
				ph_d = nlpd_pkg::PH_TRAILING;
			end
		end else if (item.last_word) begin
			if (ph_d == nlpd_pkg::PH_SKIP) begin
				status = (kind_d == nlpd_pkg::KIND_SKIP_END) ?
					nlpd_pkg::ST_NO_MORE : nlpd_pkg::ST_MORE;
			end else if (ph_d != nlpd_pkg::PH_IDLE && ph_d != nlpd_pkg::PH_DISCARD) begin
				status = nlpd_pkg::ST_ERROR;
				err_f  = nlpd_pkg::ERR_TRUNCATED;
			end
			ph_d = nlpd_pkg::PH_IDLE;
		end
	end

	always_comb begin : outputs
		res.payload_valid       = pv;
		res.payload             = pv ? item.word : '0;
		res.empty_subevent      = empty;
		res.end_of_subevent     = eos;
		res.ev_num              = (pv || empty) ? cev_d : '0;
		res.subevent_tag        = (pv || empty) ? csub_d : '0;
		res.unpacker_slot       = (pv || empty) ? cslot_d : '0;
		res.cluster_status      = status;
		res.error_code          = (status == nlpd_pkg::ST_ERROR) ? err_f : nlpd_pkg::ERR_NONE;
		res.event_cluster_total = ecc_d;
		res.event_total         = evc_d;
		res.subevent_total      = sbc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= nlpd_pkg::PH_IDLE;
			kind_q  <= nlpd_pkg::KIND_NONE;
			hp_q    <= '0;
			opt_q   <= '0;
			evl_q   <= '0;
			ewl_q   <= '0;
			sel_q   <= '0;
			scte_q  <= '0;
			swl_q   <= '0;
			eic_q   <= '0;
			cev_q   <= '0;
			csub_q  <= '0;
			cslot_q <= '0;
			ecc_q   <= '0;
			evc_q   <= '0;
			sbc_q   <= '0;
		end else if (advance) begin
			ph_q    <= ph_d;
			kind_q  <= kind_d;
			hp_q    <= hp_d;
			opt_q   <= opt_d;
			evl_q   <= evl_d;
			ewl_q   <= ewl_d;
			sel_q   <= sel_d;
			scte_q  <= scte_d;
			swl_q   <= swl_d;
			eic_q   <= eic_d;
			cev_q   <= cev_d;
			csub_q  <= csub_d;
			cslot_q <= cslot_d;
			ecc_q   <= ecc_d;
			evc_q   <= evc_d;
			sbc_q   <= sbc_d;
		end
	end

	a_status_err: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> ((res.cluster_status == nlpd_pkg::ST_ERROR) == (res.error_code != '0)))
		else $error("status and error code disagree");

	a_empty_eos: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.empty_subevent) |-> (res.end_of_subevent && !res.payload_valid))
		else $error("empty subevent without end mark");

	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ph_q == nlpd_pkg::PH_IDLE && !item.first_word) |=> ph_q == nlpd_pkg::PH_IDLE)
		else $error("left idle without a first word");

	a_ecc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ecc_q != $past(ecc_q)) |-> (ecc_q == $past(ecc_q) + 32'd1))
		else $error("cluster counter jumped");

endmodule

// ===== design/nested_length_prefixed_deframer.sv =====
// channel  dir  word fields
// in_ch    in   word[31:0], first_word, last_word
// out_ch   out  payload tags, cluster_status, error_code, totals
// cfg      in   cfg_write, cfg_index[2:0], cfg_data[31:0]
//
// One word per cycle sustained while out_ch is ready: input register,
// one pass of parse logic, result register; an out_ch stall holds both.
// in_ch.ready falls only when both registers are full and out_ch stalls.
// arst_n at once clears parse, counter and valid state and resets the config.
module nested_length_prefixed_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	nlpd_in_if.sink                      in_ch,
	nlpd_out_if.source                   out_ch,
	input  logic                         cfg_write,
	input  logic [nlpd_pkg::RegIdxW-1:0] cfg_index,
	input  logic [nlpd_pkg::WordW-1:0]   cfg_data
);

	nlpd_pkg::cfg_t cfg;
	nlpd_pkg::in_t  item_s1;
	nlpd_pkg::out_t res;
	nlpd_pkg::out_t res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           advance;
	logic           take;

	nlpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nlpd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign take         = in_ch.valid && in_ch.ready;
	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ch.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= in_ch.data;
		if (advance)
			res_s2 <= res;
	end

endmodule

// ===== tb/tb_nested_length_prefixed_deframer.sv =====
`timescale 1ns / 1ps

module tb_nested_length_prefixed_deframer;
	import nlpd_pkg::*;

	localparam int QuietLimit  = 500;
	localparam int RandomWords = 800;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [RegIdxW-1:0] cfg_index;
	logic [WordW-1:0] cfg_data;

	nlpd_in_if in_ch();
	nlpd_out_if out_ch();

	nested_length_prefixed_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register shadow and parser state
	cfg_t cfg;
	phase_t ph = PH_IDLE;
	kind_t kind = KIND_NONE;
	logic [1:0] hdr_pos = '0;
	logic [1:0] cur_slot = '0;
	logic [31:0] opts_left = '0, evs_left = '0, ev_words = '0, sevs_left = '0;
	logic [31:0] sevs_this_ev = '0, sev_words = '0, cur_ev = '0, cur_sev = '0;
	logic [31:0] n_ev_clusters = '0, n_events = '0, n_sevs = '0, evs_in_cluster = '0;
	err_t step_err;
	bit ev_done;

	out_t expected_q[$];
	logic [31:0] frame_q[$];
	int fails = 0;
	int sent_words = 0;
	int quiet = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;
	bit stall_on = 1'b1;

	function automatic void open_subevent();
		if (ev_words < 2)
			step_err = ERR_TRUNCATED;
		else
			ph = PH_SEVID;
	endfunction

	function automatic void close_event();
		if (ev_words != 0) begin
			step_err = ERR_EVENT_MISMATCH;
		end else begin
			n_sevs += sevs_this_ev;
			evs_left -= 1;
			if (evs_left == 0)
				ev_done = 1'b1;
			else
				ph = PH_EVSIZE;
		end
	endfunction

	function automatic void close_subevent();
		sevs_left -= 1;
		if (sevs_left == 0)
			close_event();
		else
			open_subevent();
	endfunction

	function automatic out_t deframe_word(in_t w);
		out_t r;
		err_t e;
		status_t st;
		bit pv, empty, eos, hit;
		logic [1:0] slot;
		r = '0;
		pv = 1'b0;
		empty = 1'b0;
		eos = 1'b0;
		hit = 1'b0;
		slot = '0;
		step_err = ERR_NONE;
		ev_done = 1'b0;
		if (w.first_word) begin
			hdr_pos = '0;
			kind = KIND_NONE;
			opts_left = '0;
			evs_left = '0;
			ev_words = '0;
			sevs_left = '0;
			sevs_this_ev = '0;
			sev_words = '0;
			evs_in_cluster = '0;
			ph = PH_ENDIAN;
		end else begin
			case (ph)
				PH_ENDIAN: ph = PH_TYPE;
				PH_TYPE: begin
					if (w.word == cfg.events_type) begin
						kind = KIND_EVENTS;
						n_ev_clusters += 1;
						ph = PH_OPTSIZE;
					end else if (w.word == cfg.end_type) begin
						kind = KIND_SKIP_END;
						ph = PH_SKIP;
					end else if (w.word < 32 && cfg.ignored_mask[w.word[4:0]]) begin
						kind = KIND_SKIP_MORE;
						ph = PH_SKIP;
					end else begin
						step_err = ERR_UNKNOWN_TYPE;
					end
				end
				PH_OPTSIZE: begin
					opts_left = w.word;
					hdr_pos = '0;
					ph = (w.word != 0) ? PH_OPTIONS : PH_HEADER;
				end
				PH_OPTIONS: begin
					opts_left -= 1;
					if (opts_left == 0)
						ph = PH_HEADER;
				end
				PH_HEADER: begin
					if (hdr_pos >= 2)
						ph = PH_NEVENTS;
					else
						hdr_pos += 1;
				end
				PH_NEVENTS: begin
					evs_left = w.word;
					evs_in_cluster = w.word;
					if (w.word == 0)
						ev_done = 1'b1;
					else
						ph = PH_EVSIZE;
				end
				PH_EVSIZE: begin
					if (w.word < 3) begin
						step_err = ERR_TRUNCATED;
					end else begin
						ev_words = w.word;
						hdr_pos = '0;
						ph = PH_EVHEAD;
					end
				end
				PH_EVHEAD: begin
					ev_words -= 1;
					if (hdr_pos == 0) begin
						cur_ev = w.word;
						hdr_pos = 1;
					end else if (hdr_pos == 1) begin
						hdr_pos = 2;
					end else begin
						sevs_left = w.word;
						sevs_this_ev = w.word;
						if (w.word == 0)
							close_event();
						else
							open_subevent();
					end
				end
				PH_SEVID: begin
					cur_sev = w.word;
					ev_words -= 1;
					ph = PH_SEVSIZE;
				end
				PH_SEVSIZE: begin
					ev_words -= 1;
					for (int s = 0; s < SlotCount; s++) begin
						if (!hit && cfg.slot_enable[s] && cfg.sub_id[s] == cur_sev) begin
							hit = 1'b1;
							slot = s[1:0];
						end
					end
					if (w.word > ev_words) begin
						step_err = ERR_TRUNCATED;
					end else if (!hit) begin
						step_err = ERR_UNKNOWN_ID;
					end else begin
						cur_slot = slot;
						sev_words = w.word;
						if (w.word == 0) begin
							empty = 1'b1;
							eos = 1'b1;
							close_subevent();
						end else begin
							ph = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					pv = 1'b1;
					r.payload = w.word;
					ev_words -= 1;
					sev_words -= 1;
					if (sev_words == 0) begin
						eos = 1'b1;
						close_subevent();
					end
				end
				PH_TRAILING: step_err = ERR_EXTRA_WORDS;
				default: ;
			endcase
		end

		// early end outranks mismatch and unknown id on the same word
		e = step_err;
		if (w.last_word && (e == ERR_EVENT_MISMATCH || e == ERR_UNKNOWN_ID))
			e = ERR_TRUNCATED;
		st = ST_RUNNING;
		if (e != ERR_NONE) begin
			st = ST_ERROR;
			ph = w.last_word ? PH_IDLE : PH_DISCARD;
		end else if (ev_done) begin
			if (w.last_word) begin
				st = ST_MORE;
				n_events += evs_in_cluster;
				ph = PH_IDLE;
			end else begin
				ph = PH_TRAILING;
			end
		end else if (w.last_word) begin
			if (ph == PH_SKIP) begin
				st = (kind == KIND_SKIP_END) ? ST_NO_MORE : ST_MORE;
			end else if (ph != PH_IDLE && ph != PH_DISCARD) begin
				st = ST_ERROR;
				e = ERR_TRUNCATED;
			end
			ph = PH_IDLE;
		end

		r.payload_valid = pv;
		r.empty_subevent = empty;
		r.end_of_subevent = eos;
		if (pv || empty) begin
			r.ev_num = cur_ev;
			r.subevent_tag = cur_sev;
			r.unpacker_slot = cur_slot;
		end
		r.cluster_status = st;
		r.error_code = (st == ST_ERROR) ? e : ERR_NONE;
		r.event_cluster_total = n_ev_clusters;
		r.event_total = n_events;
		r.subevent_total = n_sevs;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				want = expected_q.pop_front();
				check_field("payload_valid", want.payload_valid, out_ch.data.payload_valid);
				check_field("payload", want.payload, out_ch.data.payload);
				check_field("empty_subevent", want.empty_subevent, out_ch.data.empty_subevent);
				check_field("end_of_subevent", want.end_of_subevent,
					out_ch.data.end_of_subevent);
				check_field("ev_num", want.ev_num, out_ch.data.ev_num);
				check_field("subevent_tag", want.subevent_tag, out_ch.data.subevent_tag);
				check_field("unpacker_slot", want.unpacker_slot, out_ch.data.unpacker_slot);
				check_field("cluster_status", want.cluster_status, out_ch.data.cluster_status);
				check_field("error_code", want.error_code, out_ch.data.error_code);
				check_field("event_cluster_total", want.event_cluster_total,
					out_ch.data.event_cluster_total);
				check_field("event_total", want.event_total, out_ch.data.event_total);
				check_field("subevent_total", want.subevent_total, out_ch.data.subevent_total);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QuietLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(logic [31:0] w, bit first, bit last);
		in_t item;
		item.word = w;
		item.first_word = first;
		item.last_word = last;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= item;
		do @(posedge clk); while (!in_ch.ready);
		sent_words++;
		expected_q.push_back(deframe_word(item));
	endtask

	task automatic send_frame(bit with_last);
		foreach (frame_q[i])
			send_word(frame_q[i], i == 0, with_last && i == frame_q.size() - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_SUB_ID_0, REG_SUB_ID_1, REG_SUB_ID_2, REG_SUB_ID_3:
				cfg.sub_id[int'(idx)] = v;
			REG_SLOT_ENABLE: cfg.slot_enable = v[IdCount-1:0];
			REG_EVENTS_TYPE: cfg.events_type = v;
			REG_END_TYPE: cfg.end_type = v;
			REG_IGNORED_MASK: cfg.ignored_mask = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic load_config(cfg_t c);
		for (int i = 0; i < IdCount; i++)
			write_reg(reg_idx_t'(REG_SUB_ID_0 + i), c.sub_id[i]);
		write_reg(REG_SLOT_ENABLE, {{(WordW-IdCount){1'b0}}, c.slot_enable});
		write_reg(REG_EVENTS_TYPE, c.events_type);
		write_reg(REG_END_TYPE, c.end_type);
		write_reg(REG_IGNORED_MASK, c.ignored_mask);
	endtask

	function automatic cfg_t pick_setting(int n);
		cfg_t c;
		c = '0;
		c.slot_enable = '1;
		if (n == 0) begin
			c.end_type = '0;
		end else if (n == 1) begin
			c = '1;
		end else begin
			for (int i = 0; i < IdCount; i++)
				c.sub_id[i] = ($urandom_range(0, 3) == 0) ? i : $urandom;
			if ($urandom_range(0, 2) == 0)
				c.sub_id[2] = c.sub_id[0];
			c.slot_enable = (n == 2) ? '0 : $urandom_range(1, 15);
			c.events_type = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom;
			c.end_type = $urandom_range(0, 1) ? EndTypeReset : $urandom;
			c.ignored_mask = $urandom;
		end
		return c;
	endfunction

	task automatic send_random_frame();
		int pick, n_opt, n_ev, n_sev, len, ev_at, s, cut;
		bit with_last;
		pick = $urandom_range(0, 19);
		with_last = 1'b1;
		frame_q.delete();
		if (pick < 13) begin
			frame_q.push_back($urandom);
			frame_q.push_back($urandom);
			frame_q.push_back(cfg.events_type);
			n_opt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			frame_q.push_back(n_opt);
			repeat (n_opt) frame_q.push_back($urandom);
			repeat (3) frame_q.push_back($urandom);
			n_ev = $urandom_range(0, 3);
			frame_q.push_back(n_ev);
			repeat (n_ev) begin
				ev_at = frame_q.size();
				frame_q.push_back(0);
				frame_q.push_back($urandom);
				frame_q.push_back($urandom);
				n_sev = $urandom_range(0, 3);
				frame_q.push_back(n_sev);
				repeat (n_sev) begin
					if (cfg.slot_enable != 0 && $urandom_range(0, 9) != 0) begin
						do s = $urandom_range(0, SlotCount - 1); while (!cfg.slot_enable[s]);
						frame_q.push_back(cfg.sub_id[s]);
					end else begin
						frame_q.push_back($urandom);
					end
					len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 4);
					frame_q.push_back(len);
					repeat (len) frame_q.push_back($urandom);
				end
				frame_q[ev_at] = frame_q.size() - ev_at - 1;
			end
			frame_q[0] = frame_q.size();
			// damage some of the well-formed clusters
			case ($urandom_range(0, 11))
				0: frame_q[$urandom_range(3, frame_q.size() - 1)] = $urandom_range(0, 6);
				1: frame_q[$urandom_range(3, frame_q.size() - 1)] = $urandom;
				2: begin
					cut = $urandom_range(1, frame_q.size() - 1);
					while (frame_q.size() > cut) frame_q.delete(frame_q.size() - 1);
				end
				3: frame_q.push_back($urandom);
				4: with_last = 1'b0;
				default: ;
			endcase
		end else if (pick < 15) begin
			frame_q.push_back($urandom);
			frame_q.push_back($urandom);
			if ($urandom_range(0, 1) || cfg.ignored_mask == 0) begin
				frame_q.push_back(cfg.end_type);
			end else begin
				do s = $urandom_range(0, 31); while (!cfg.ignored_mask[s]);
				frame_q.push_back(s);
			end
			repeat ($urandom_range(0, 3)) frame_q.push_back($urandom);
		end else if (pick < 17) begin
			repeat ($urandom_range(3, 6)) frame_q.push_back($urandom);
		end else if (pick < 19) begin
			repeat ($urandom_range(1, 6))
				send_word($urandom, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
		end else begin
			send_word($urandom, 1'b0, $urandom_range(0, 1));
		end
		if (frame_q.size() != 0)
			send_frame(with_last);
	endtask

	task automatic test_reset_defaults();
		send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		frame_q = '{32'd3, 32'h0, EndTypeReset};
		send_frame(1'b1);
		frame_q = '{32'd8, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
		send_frame(1'b1);
		frame_q = '{32'd4, 32'h0, 32'd4, 32'h0};
		send_frame(1'b1);
		frame_q = '{32'd4, 32'h0, 32'd3, 32'hFFFF_FFFF};
		send_frame(1'b1);
	endtask

	task automatic test_event_cluster();
		cfg_t c;
		c = '0;
		c.sub_id[1] = 32'hFFFF_FFFF;
		c.sub_id[2] = 32'h0000_1234;
		c.sub_id[3] = 32'h8000_0001;
		c.slot_enable = 4'b1010;
		c.events_type = 32'd32;
		c.end_type = EndTypeReset;
		c.ignored_mask = IgnoredMaskReset;
		drain();
		load_config(c);
		// empty subevent, then two payload words at the extremes
		frame_q = '{32'd19, 32'h0, 32'd32, 32'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
			32'd1, 32'd9, 32'hFFFF_FFFF, 32'h0, 32'd2, c.sub_id[3], 32'd0,
			c.sub_id[1], 32'd2, 32'h0, 32'hFFFF_FFFF};
		send_frame(1'b1);
	endtask

	task automatic test_random_clusters();
		int n;
		n = 0;
		while (sent_words < RandomWords) begin
			drain();
			load_config(pick_setting(n));
			n++;
			repeat ($urandom_range(6, 12)) begin
				if (sent_words > RandomWords - 150) begin
					idle_on = 1'b0;
					stall_on = 1'b0;
				end
				if (sent_words < RandomWords)
					send_random_frame();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SUB_ID_0;
		cfg_data = '0;
		cfg = '0;
		cfg.end_type = EndTypeReset;
		cfg.ignored_mask = IgnoredMaskReset;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_event_cluster();
		test_random_clusters();
		drain();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
